@@ sv/spi_flash_memory_map_controller_macros.svh @@
// Assertion macros used by the checker of the SPI flash controller.
`ifndef SPI_FLASH_MEMORY_MAP_CONTROLLER_MACROS_SVH
`define SPI_FLASH_MEMORY_MAP_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SFMC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfmc assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SFMC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfmc assertion failed");

`endif

@@ sv/sfmc_pkg.sv @@
// Types, constants and step ROM of the SPI flash memory-mapped controller.
package sfmc_pkg;

   localparam int unsigned WINDOW_ADDRESS_BITS_DEFAULT = 24;

   // Bus and reply commands
   localparam logic [2:0] CMD_WIN_READ  = 3'd0;
   localparam logic [2:0] CMD_WIN_WRITE = 3'd1;
   localparam logic [2:0] CMD_REG_READ  = 3'd2;
   localparam logic [2:0] CMD_REG_WRITE = 3'd3;
   localparam logic [2:0] CMD_REPLY     = 3'd4;

   // Register offsets
   localparam logic [23:0] REG_DATA = 24'h000000;
   localparam logic [23:0] REG_QUAD = 24'h000002;
   localparam logic [23:0] REG_CTRL = 24'h000004;
   localparam logic [23:0] REG_CFG  = 24'h000008;

   localparam logic [31:0] CFG_RESET = 32'h0000_0003;

   typedef enum logic [1:0] {
      KIND_XFER  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WREAD = 2'd1,
      PH_RREAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [23:0] address;
      logic [63:0] write_data;
      logic [3:0]  access_bytes;
      logic [7:0]  reply_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  send_byte;
      logic        chip_select_active;
      logic        wants_reply;
      logic [63:0] read_data;
      logic        last;
   } rsp_type;

   // Step ROM addresses
   typedef enum logic [4:0] {
      ST_R_OPC   = 5'd0,
      ST_R_ADDR  = 5'd1,
      ST_R_DUMMY = 5'd2,
      ST_R_REQ   = 5'd3,
      ST_W_OPC   = 5'd4,
      ST_W_ADDR  = 5'd5,
      ST_W_DUMMY = 5'd6,
      ST_W_DATA  = 5'd7,
      ST_W_DONE  = 5'd8,
      ST_RR_DATA = 5'd9,
      ST_RR_CTRL = 5'd10,
      ST_RR_CFG  = 5'd11,
      ST_RR_BAD  = 5'd12,
      ST_RW_DATA = 5'd13,
      ST_RW_DONE = 5'd14,
      ST_RP_MORE = 5'd15,
      ST_RP_DONE = 5'd16,
      ST_RP_REG  = 5'd17
   } step_type;

   typedef enum logic [2:0] {
      SEND_ZERO   = 3'd0,
      SEND_OPCODE = 3'd1,
      SEND_ADDR   = 3'd2,
      SEND_FF     = 3'd3,
      SEND_WDATA  = 3'd4,
      SEND_WLOW   = 3'd5
   } send_sel_type;

   typedef enum logic [1:0] {
      CS_LOW   = 2'd0,
      CS_HIGH  = 2'd1,
      CS_LEVEL = 2'd2
   } cs_sel_type;

   typedef enum logic [2:0] {
      DATA_ZERO  = 3'd0,
      DATA_CFG   = 3'd1,
      DATA_ONES  = 3'd2,
      DATA_ACC   = 3'd3,
      DATA_REPLY = 3'd4
   } data_sel_type;

   typedef enum logic {
      BR_NEXT       = 1'b0,
      BR_SKIP_DUMMY = 1'b1
   } branch_type;

   typedef enum logic [1:0] {
      CNT_NONE  = 2'd0,
      CNT_ADDR  = 2'd1,
      CNT_DUMMY = 2'd2,
      CNT_SIZE  = 2'd3
   } cnt_init_type;

   typedef struct packed {
      kind_type     kind;
      send_sel_type send_sel;
      cs_sel_type   cs_sel;
      logic         want;
      data_sel_type data_sel;
      logic         last;
      logic         loop;
      branch_type   branch;
      cnt_init_type cnt_init;
      step_type     target;
   } ctl_word_type;

   typedef struct packed {
      logic     start;
      step_type entry;
   } seq_cmd_type;

   typedef struct packed {
      logic       no_dummy;
      logic       four_byte;
      logic [2:0] size_m1;
   } seq_cond_type;

   // Byte-lane mask for an access of sz bytes (1 to 8).
   function automatic logic [63:0] size_mask(input logic [3:0] sz);
      logic [63:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (4'(i) < sz) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

   // Control word for each step of the microprogram.
   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = '{kind: KIND_XFER, send_sel: SEND_ZERO, cs_sel: CS_HIGH, want: 1'b0,
            data_sel: DATA_ZERO, last: 1'b0, loop: 1'b0, branch: BR_NEXT,
            cnt_init: CNT_NONE, target: ST_R_OPC};
      unique case (step)
         ST_R_OPC: begin
            w.send_sel = SEND_OPCODE;
         end
         ST_R_ADDR: begin
            w.send_sel = SEND_ADDR;
            w.loop     = 1'b1;
            w.cnt_init = CNT_ADDR;
            w.branch   = BR_SKIP_DUMMY;
            w.target   = ST_R_REQ;
         end
         ST_R_DUMMY: begin
            w.send_sel = SEND_FF;
            w.loop     = 1'b1;
            w.cnt_init = CNT_DUMMY;
         end
         ST_R_REQ: begin
            w.want = 1'b1;
            w.last = 1'b1;
         end
         ST_W_OPC: begin
            w.send_sel = SEND_OPCODE;
         end
         ST_W_ADDR: begin
            w.send_sel = SEND_ADDR;
            w.loop     = 1'b1;
            w.cnt_init = CNT_ADDR;
            w.branch   = BR_SKIP_DUMMY;
            w.target   = ST_W_DATA;
         end
         ST_W_DUMMY: begin
            w.send_sel = SEND_FF;
            w.loop     = 1'b1;
            w.cnt_init = CNT_DUMMY;
         end
         ST_W_DATA: begin
            w.send_sel = SEND_WDATA;
            w.loop     = 1'b1;
            w.cnt_init = CNT_SIZE;
         end
         ST_W_DONE: begin
            w.kind   = KIND_WRITE;
            w.cs_sel = CS_LOW;
            w.last   = 1'b1;
         end
         ST_RR_DATA: begin
            w.cs_sel = CS_LEVEL;
            w.want   = 1'b1;
            w.last   = 1'b1;
         end
         ST_RR_CTRL: begin
            w.kind   = KIND_READ;
            w.cs_sel = CS_LEVEL;
            w.last   = 1'b1;
         end
         ST_RR_CFG: begin
            w.kind     = KIND_READ;
            w.cs_sel   = CS_LEVEL;
            w.data_sel = DATA_CFG;
            w.last     = 1'b1;
         end
         ST_RR_BAD: begin
            w.kind     = KIND_READ;
            w.cs_sel   = CS_LEVEL;
            w.data_sel = DATA_ONES;
            w.last     = 1'b1;
         end
         ST_RW_DATA: begin
            w.send_sel = SEND_WLOW;
            w.cs_sel   = CS_LEVEL;
         end
         ST_RW_DONE: begin
            w.kind   = KIND_WRITE;
            w.cs_sel = CS_LEVEL;
            w.last   = 1'b1;
         end
         ST_RP_MORE: begin
            w.want = 1'b1;
            w.last = 1'b1;
         end
         ST_RP_DONE: begin
            w.kind     = KIND_READ;
            w.cs_sel   = CS_LOW;
            w.data_sel = DATA_ACC;
            w.last     = 1'b1;
         end
         ST_RP_REG: begin
            w.kind     = KIND_READ;
            w.cs_sel   = CS_LEVEL;
            w.data_sel = DATA_REPLY;
            w.last     = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

@@ sv/spi_flash_memory_map_controller.sv @@
// Top level of the memory-mapped SPI flash controller.
//
//   channel | ports                              | direction | moves
//   --------+------------------------------------+-----------+------------------------------
//   req     | req_valid, req_stall, req_payload  | in        | bus access or SPI reply byte
//   rsp     | rsp_valid, rsp_stall, rsp_payload  | out       | SPI byte, read data, write done
//
// An accepted item is decoded in its transfer cycle into a start address of the step ROM;
// the sequencer then issues one result per cycle into the output register while that
// register is free or being taken, one ROM step (or one repeat of a looping step) per result.
// The longest item is an 8-byte window write with 4 address bytes and dummy bytes (22 results).
// req_stall stays high while the sequencer runs; rsp_stall only holds the output register
// and the step in progress. Reset is synchronous and clears all control state at once.
module spi_flash_memory_map_controller #(
   parameter int unsigned WINDOW_ADDRESS_BITS = sfmc_pkg::WINDOW_ADDRESS_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sfmc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sfmc_pkg::rsp_type rsp_payload
);

   // Window address mask, at most 32 bits wide
   localparam logic [32:0] WIN_MASK_WIDE = (33'd1 << WINDOW_ADDRESS_BITS) - 33'd1;
   localparam logic [31:0] WIN_MASK      = WIN_MASK_WIDE[31:0];

   // Architectural state
   logic [31:0]         config_ff, config_in;
   logic                select_ff, select_in;
   sfmc_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          remaining_ff, remaining_in;
   logic [63:0]         acc_ff, acc_in;
   logic [3:0]          pending_ff, pending_in;

   // Latched item fields for the running program
   logic [23:0] addr_ff, addr_in;
   logic [63:0] wdata_ff, wdata_in;
   logic [3:0]  size_ff, size_in;
   logic [7:0]  reply_ff, reply_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   sfmc_pkg::rsp_type rsp_ff, rsp_in;

   // Sequencer interface
   sfmc_pkg::seq_cmd_type  seq_cmd;
   sfmc_pkg::seq_cond_type seq_cond;
   sfmc_pkg::ctl_word_type seq_ctl;
   logic [2:0]             seq_cnt;
   logic                   seq_busy;
   logic                   emit;

   logic       accept;
   logic [3:0] size_norm;
   logic [3:0] reg_size_norm;
   logic [2:0] acc_idx;
   logic [3:0] remaining_dec;

   // Emit-side helpers
   logic [31:0] win_addr;
   logic [3:0]  reg_size;
   logic [2:0]  wdata_idx;
   logic [7:0]  send_mux;
   logic        cs_mux;
   logic [63:0] data_mux;

   assign accept    = req_valid && !req_stall;
   assign req_stall = seq_busy;
   assign emit      = seq_busy && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign seq_cond.no_dummy  = (config_ff[10:8] == 3'd0);
   assign seq_cond.four_byte = config_ff[13];
   assign seq_cond.size_m1   = 3'(size_ff - 4'd1);

   sfmc_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .seq_cmd     (seq_cmd),
      .seq_cond    (seq_cond),
      .seq_advance (emit),
      .seq_ctl     (seq_ctl),
      .seq_cnt     (seq_cnt),
      .seq_busy    (seq_busy)
   );

   // Clamp access size: zero counts as one, above eight as eight, registers to four
   always_comb begin
      if (req_payload.access_bytes == 4'd0) begin
         size_norm = 4'd1;
      end else if (req_payload.access_bytes > 4'd8) begin
         size_norm = 4'd8;
      end else begin
         size_norm = req_payload.access_bytes;
      end
      reg_size_norm = (size_norm > 4'd4) ? 4'd4 : size_norm;
   end

   assign acc_idx       = 3'(pending_ff - remaining_ff);
   assign remaining_dec = remaining_ff - 4'd1;

   // Decode the accepted item: update state and pick the microprogram entry
   always_comb begin
      config_in     = config_ff;
      select_in     = select_ff;
      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      acc_in        = acc_ff;
      pending_in    = pending_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      size_in       = size_ff;
      reply_in      = reply_ff;
      seq_cmd.start = 1'b0;
      seq_cmd.entry = sfmc_pkg::ST_R_OPC;

      if (accept) begin
         addr_in  = req_payload.address;
         wdata_in = req_payload.write_data;
         size_in  = size_norm;
         reply_in = req_payload.reply_byte;

         if (req_payload.command == sfmc_pkg::CMD_REPLY) begin
            // Replies count only while one is awaited
            if (phase_ff == sfmc_pkg::PH_WREAD) begin
               acc_in[{acc_idx, 3'b000} +: 8] =
                  acc_ff[{acc_idx, 3'b000} +: 8] | req_payload.reply_byte;
               remaining_in  = remaining_dec;
               seq_cmd.start = 1'b1;
               if (remaining_dec != 4'd0) begin
                  seq_cmd.entry = sfmc_pkg::ST_RP_MORE;
               end else begin
                  select_in     = 1'b0;
                  phase_in      = sfmc_pkg::PH_IDLE;
                  seq_cmd.entry = sfmc_pkg::ST_RP_DONE;
               end
            end else if (phase_ff == sfmc_pkg::PH_RREAD) begin
               phase_in      = sfmc_pkg::PH_IDLE;
               seq_cmd.start = 1'b1;
               seq_cmd.entry = sfmc_pkg::ST_RP_REG;
            end
         end else if (phase_ff == sfmc_pkg::PH_IDLE) begin
            // Bus accesses while a reply is awaited are dropped
            unique case (req_payload.command)
               sfmc_pkg::CMD_WIN_READ: begin
                  select_in     = 1'b1;
                  phase_in      = sfmc_pkg::PH_WREAD;
                  remaining_in  = size_norm;
                  pending_in    = size_norm;
                  acc_in        = 64'd0;
                  seq_cmd.start = 1'b1;
                  seq_cmd.entry = sfmc_pkg::ST_R_OPC;
               end
               sfmc_pkg::CMD_WIN_WRITE: begin
                  // Chip select drops at the end; the program drives it for the transfers
                  select_in     = 1'b0;
                  seq_cmd.start = 1'b1;
                  seq_cmd.entry = sfmc_pkg::ST_W_OPC;
               end
               sfmc_pkg::CMD_REG_READ: begin
                  seq_cmd.start = 1'b1;
                  if (req_payload.address <= sfmc_pkg::REG_QUAD) begin
                     phase_in      = sfmc_pkg::PH_RREAD;
                     pending_in    = reg_size_norm;
                     seq_cmd.entry = sfmc_pkg::ST_RR_DATA;
                  end else if (req_payload.address == sfmc_pkg::REG_CTRL) begin
                     seq_cmd.entry = sfmc_pkg::ST_RR_CTRL;
                  end else if (req_payload.address == sfmc_pkg::REG_CFG) begin
                     seq_cmd.entry = sfmc_pkg::ST_RR_CFG;
                  end else begin
                     seq_cmd.entry = sfmc_pkg::ST_RR_BAD;
                  end
               end
               sfmc_pkg::CMD_REG_WRITE: begin
                  seq_cmd.start = 1'b1;
                  seq_cmd.entry = sfmc_pkg::ST_RW_DONE;
                  if (req_payload.address == sfmc_pkg::REG_DATA) begin
                     seq_cmd.entry = sfmc_pkg::ST_RW_DATA;
                  end else if (req_payload.address == sfmc_pkg::REG_CTRL) begin
                     if (req_payload.write_data[0]) begin
                        // Soft reset: restore every state entry
                        config_in    = sfmc_pkg::CFG_RESET;
                        select_in    = 1'b0;
                        phase_in     = sfmc_pkg::PH_IDLE;
                        remaining_in = 4'd0;
                        acc_in       = 64'd0;
                        pending_in   = 4'd0;
                     end else begin
                        select_in = req_payload.write_data[1];
                     end
                  end else if (req_payload.address == sfmc_pkg::REG_CFG) begin
                     config_in = req_payload.write_data[31:0];
                  end
               end
               default: begin
                  seq_cmd.start = 1'b0;
               end
            endcase
         end
      end
   end

   // Datapath driven by the current control word
   assign win_addr  = {8'd0, addr_ff} & WIN_MASK;
   assign reg_size  = (size_ff > 4'd4) ? 4'd4 : size_ff;
   assign wdata_idx = 3'(size_ff - 4'd1 - {1'b0, seq_cnt});

   always_comb begin
      unique case (seq_ctl.send_sel)
         sfmc_pkg::SEND_ZERO:   send_mux = 8'h00;
         sfmc_pkg::SEND_OPCODE: send_mux = {1'b0, config_ff[6:0]};
         sfmc_pkg::SEND_ADDR:   send_mux = win_addr[{seq_cnt[1:0], 3'b000} +: 8];
         sfmc_pkg::SEND_FF:     send_mux = 8'hff;
         sfmc_pkg::SEND_WDATA:  send_mux = wdata_ff[{wdata_idx, 3'b000} +: 8];
         sfmc_pkg::SEND_WLOW:   send_mux = wdata_ff[7:0];
         default:               send_mux = 8'h00;
      endcase

      unique case (seq_ctl.cs_sel)
         sfmc_pkg::CS_LOW:   cs_mux = 1'b0;
         sfmc_pkg::CS_HIGH:  cs_mux = 1'b1;
         sfmc_pkg::CS_LEVEL: cs_mux = select_ff;
         default:            cs_mux = 1'b0;
      endcase

      unique case (seq_ctl.data_sel)
         sfmc_pkg::DATA_ZERO:  data_mux = 64'd0;
         sfmc_pkg::DATA_CFG:   data_mux = {32'd0, config_ff} & sfmc_pkg::size_mask(reg_size);
         sfmc_pkg::DATA_ONES:  data_mux = sfmc_pkg::size_mask(reg_size);
         sfmc_pkg::DATA_ACC:   data_mux = acc_ff;
         sfmc_pkg::DATA_REPLY: data_mux = {56'd0, reply_ff} & sfmc_pkg::size_mask(pending_ff);
         default:              data_mux = 64'd0;
      endcase
   end

   // Load the output register on each step; drop valid once the transfer is taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in              = 1'b1;
         rsp_in.kind               = seq_ctl.kind;
         rsp_in.send_byte          = send_mux;
         rsp_in.chip_select_active = cs_mux;
         rsp_in.wants_reply        = seq_ctl.want;
         rsp_in.read_data          = data_mux;
         rsp_in.last               = seq_ctl.last && !(seq_ctl.loop && seq_cnt != 3'd0);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         config_ff    <= sfmc_pkg::CFG_RESET;
         select_ff    <= 1'b0;
         phase_ff     <= sfmc_pkg::PH_IDLE;
         remaining_ff <= 4'd0;
         acc_ff       <= 64'd0;
         pending_ff   <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         config_ff    <= config_in;
         select_ff    <= select_in;
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         acc_ff       <= acc_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      size_ff  <= size_in;
      reply_ff <= reply_in;
      rsp_ff   <= rsp_in;
   end

endmodule

@@ sv/sfmc_sequencer.sv @@
// Microcode sequencer: step counter, repeat counter and step ROM.
module sfmc_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  sfmc_pkg::seq_cmd_type seq_cmd,
   input  sfmc_pkg::seq_cond_type seq_cond,
   input  logic                  seq_advance,
   output sfmc_pkg::ctl_word_type seq_ctl,
   output logic [2:0]            seq_cnt,
   output logic                  seq_busy
);

   sfmc_pkg::step_type     pc_ff, pc_in, dest;
   logic [2:0]             cnt_ff, cnt_in, dest_cnt;
   logic                   busy_ff, busy_in;
   sfmc_pkg::ctl_word_type dest_word;

   assign seq_ctl  = sfmc_pkg::ucode(pc_ff);
   assign seq_cnt  = cnt_ff;
   assign seq_busy = busy_ff;

   assign dest = (seq_ctl.branch == sfmc_pkg::BR_SKIP_DUMMY && seq_cond.no_dummy)
                 ? seq_ctl.target : sfmc_pkg::step_type'(pc_ff + 5'd1);
   assign dest_word = sfmc_pkg::ucode(dest);

   always_comb begin
      unique case (dest_word.cnt_init)
         sfmc_pkg::CNT_NONE:  dest_cnt = 3'd0;
         sfmc_pkg::CNT_ADDR:  dest_cnt = seq_cond.four_byte ? 3'd3 : 3'd2;
         sfmc_pkg::CNT_DUMMY: dest_cnt = 3'd7;
         sfmc_pkg::CNT_SIZE:  dest_cnt = seq_cond.size_m1;
         default:             dest_cnt = 3'd0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (seq_cmd.start) begin
         pc_in   = seq_cmd.entry;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (seq_advance) begin
         if (seq_ctl.loop && cnt_ff != 3'd0) begin
            cnt_in = cnt_ff - 3'd1;
         end else if (seq_ctl.last) begin
            busy_in = 1'b0;
         end else begin
            pc_in  = dest;
            cnt_in = dest_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= sfmc_pkg::ST_R_OPC;
         cnt_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

endmodule

@@ sv/sfmc_checker.sv @@
// Port-level checker for the SPI flash controller, bound to the top level.
`include "spi_flash_memory_map_controller_macros.svh"

module sfmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sfmc_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sfmc_pkg::rsp_type rsp_payload
);

   // A stalled request keeps its valid and its payload
   `SFMC_ASSERT_NXT(a_req_hold, clock, reset, req_valid && req_stall,
                    req_valid && $stable(req_payload))

   // A result held by the receiver keeps its payload
   `SFMC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   // A transfer that awaits a reply ends its item
   `SFMC_ASSERT_IMP(a_want_last, clock, reset, rsp_valid && rsp_payload.wants_reply,
                    rsp_payload.last)

   // Read responses and write completions always end their item
   `SFMC_ASSERT_IMP(a_resp_last, clock, reset,
                    rsp_valid && rsp_payload.kind != sfmc_pkg::KIND_XFER, rsp_payload.last)

   // While an item's results are still coming, no new item is taken
   `SFMC_ASSERT_IMP(a_busy_stall, clock, reset, rsp_valid && !rsp_payload.last, req_stall)

endmodule

bind spi_flash_memory_map_controller sfmc_checker u_sfmc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
